// ----- src/dqsa_pkg.sv -----
// ----------------------------------------------------------------------------
// dqsa_pkg
// Shared codes and controller/datapath interface types for the deque block.
// ----------------------------------------------------------------------------
package dqsa_pkg;

	localparam int FUNC_W = 3;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int RSEL_W = 3;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_PUSH_BACK = 3'd0;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_BACK  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SEARCH    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_SIZE      = 3'd4;
	localparam logic [FUNC_W-1:0] FN_AVERAGE   = 3'd5;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

	// result selection
	localparam logic [RSEL_W-1:0] RES_ZERO  = 3'd0;
	localparam logic [RSEL_W-1:0] RES_EMPTY = 3'd1;
	localparam logic [RSEL_W-1:0] RES_FULL  = 3'd2;
	localparam logic [RSEL_W-1:0] RES_MISS  = 3'd3;
	localparam logic [RSEL_W-1:0] RES_SIZE  = 3'd4;
	localparam logic [RSEL_W-1:0] RES_POS   = 3'd5;
	localparam logic [RSEL_W-1:0] RES_AVG   = 3'd6;

	typedef struct packed {
		logic              latch;
		logic              push;
		logic              rd_front;
		logic              rd_back;
		logic              pop_front;
		logic              pop_back;
		logic              srch_init;
		logic              srch_step;
		logic              div_start;
		logic              res_load;
		logic [RSEL_W-1:0] res_sel;
	} dqsa_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              empty;
		logic              full;
		logic              match;
		logic              last;
		logic              div_done;
	} dqsa_stat_t;

endpackage

// ----- src/dqsa_div.sv -----
// ----------------------------------------------------------------------------
// dqsa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dqsa_div #(
	parameter int N = 41,
	parameter int D = 9
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic [N-1:0] quotient,
	output logic         done
);
	localparam int CW = $clog2(N + 1);

	logic [N-1:0]  quo_q;
	logic [D-1:0]  rem_q;
	logic [D-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [D:0]    shifted;
	logic [D:0]    diff;
	logic          take;

	assign shifted = {rem_q, quo_q[N-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign take    = (shifted >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(N - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			// remainder stays below the divisor, so it fits D bits
			rem_q <= take ? diff[D-1:0] : shifted[D-1:0];
			quo_q <= {quo_q[N-2:0], take};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ----- src/dqsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// dqsa_ctrl
// Operation sequencer: decodes each word and steers the datapath.
// ----------------------------------------------------------------------------
module dqsa_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  dqsa_pkg::dqsa_stat_t   stat,
	output dqsa_pkg::dqsa_cmd_t    cmd,
	output logic                   busy
);
	import dqsa_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_POP  = 3'd2;
	localparam logic [2:0] S_SRCH = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.latch = start;
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.res_load = 1'b1;
				state_d      = S_IDLE;
				case (stat.func)
					FN_PUSH_BACK: begin
						if (stat.full) begin
							cmd.res_sel = RES_FULL;
						end else begin
							cmd.push    = 1'b1;
							cmd.res_sel = RES_ZERO;
						end
					end
					FN_POP_FRONT, FN_POP_BACK: begin
						if (stat.empty) begin
							cmd.res_sel = RES_EMPTY;
						end else begin
							cmd.res_load = 1'b0;
							cmd.rd_front = (stat.func == FN_POP_FRONT);
							cmd.rd_back  = (stat.func == FN_POP_BACK);
							state_d      = S_POP;
						end
					end
					FN_SEARCH: begin
						if (stat.empty) begin
							cmd.res_sel = RES_MISS;
						end else begin
							cmd.res_load  = 1'b0;
							cmd.srch_init = 1'b1;
							state_d       = S_SRCH;
						end
					end
					FN_SIZE: cmd.res_sel = RES_SIZE;
					FN_AVERAGE: begin
						if (stat.empty) begin
							cmd.res_sel = RES_EMPTY;
						end else begin
							cmd.res_load  = 1'b0;
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
					end
					default: cmd.res_sel = RES_ZERO;
				endcase
			end
			S_POP: begin
				cmd.pop_front = (stat.func == FN_POP_FRONT);
				cmd.pop_back  = (stat.func != FN_POP_FRONT);
				cmd.res_load  = 1'b1;
				cmd.res_sel   = RES_ZERO;
				state_d       = S_IDLE;
			end
			S_SRCH: begin
				if (stat.match) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_POS;
					state_d      = S_IDLE;
				end else if (stat.last) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_MISS;
					state_d      = S_IDLE;
				end else begin
					cmd.srch_step = 1'b1;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_AVG;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- src/dqsa_dp.sv -----
// ----------------------------------------------------------------------------
// dqsa_dp
// Datapath: ring buffer memory, pointers, running sum, search walk, divider
// and result register.
// ----------------------------------------------------------------------------
module dqsa_dp #(
	parameter int CAPACITY = 256,
	parameter int IDX_W    = 8,
	parameter int CNT_W    = 9,
	parameter int SUM_W    = 41
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dqsa_pkg::dqsa_cmd_t                cmd,
	output dqsa_pkg::dqsa_stat_t               stat,
	input  logic [dqsa_pkg::FUNC_W-1:0]        func,
	input  logic signed [dqsa_pkg::DATA_W-1:0] value,
	output logic                               done,
	output logic [dqsa_pkg::STAT_W-1:0]        status,
	output logic signed [dqsa_pkg::DATA_W-1:0] answer
);
	import dqsa_pkg::*;

	localparam int PW = IDX_W + 1;

	logic [DATA_W-1:0] mem [CAPACITY];
	logic [DATA_W-1:0] rdata_q;

	logic [FUNC_W-1:0] func_q;
	logic [DATA_W-1:0] value_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [IDX_W-1:0]  rptr_q;
	logic [IDX_W-1:0]  cmp_idx_q;
	logic              avg_neg_q;
	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] answer_q;

	logic [IDX_W-1:0]  push_pos;
	logic [IDX_W-1:0]  back_pos;
	logic [IDX_W-1:0]  next_head;
	logic [IDX_W-1:0]  next_rptr;
	logic [IDX_W-1:0]  rd_addr;
	logic              rd_en;
	logic [SUM_W-1:0]  sum_mag;
	logic [SUM_W-1:0]  quotient;
	logic              div_done;
	logic [DATA_W-1:0] quo_lo;
	logic [DATA_W-1:0] avg;

	function automatic logic [IDX_W-1:0] ring(input logic [PW-1:0] p);
		logic [PW-1:0] q;
		q = (p >= PW'(CAPACITY)) ? p - PW'(CAPACITY) : p;
		return q[IDX_W-1:0];
	endfunction

	assign push_pos  = ring(PW'(head_q) + PW'(count_q));
	assign back_pos  = ring(PW'(head_q) + PW'(count_q) - PW'(1));
	assign next_head = ring(PW'(head_q) + PW'(1));
	assign next_rptr = ring(PW'(rptr_q) + PW'(1));

	always_comb begin
		rd_addr = head_q;
		if (cmd.rd_back)        rd_addr = back_pos;
		else if (cmd.srch_step) rd_addr = rptr_q;
	end
	assign rd_en = cmd.rd_front | cmd.rd_back | cmd.srch_init | cmd.srch_step;

	always_ff @(posedge clk) begin
		if (cmd.push) mem[push_pos] <= value_q;
		if (rd_en)    rdata_q <= mem[rd_addr];
	end

	// operand latch, search walk pointers and average sign
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q  <= func;
			value_q <= value;
		end
		if (cmd.srch_init) begin
			rptr_q    <= next_head;
			cmp_idx_q <= '0;
		end else if (cmd.srch_step) begin
			rptr_q    <= next_rptr;
			cmp_idx_q <= cmp_idx_q + IDX_W'(1);
		end
		if (cmd.div_start) avg_neg_q <= sum_q[SUM_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + CNT_W'(1);
				sum_q   <= sum_q + {{(SUM_W-DATA_W){value_q[DATA_W-1]}}, value_q};
			end else if (cmd.pop_front || cmd.pop_back) begin
				count_q <= count_q - CNT_W'(1);
				sum_q   <= sum_q - {{(SUM_W-DATA_W){rdata_q[DATA_W-1]}}, rdata_q};
				if (cmd.pop_front) head_q <= next_head;
			end
		end
	end

	assign sum_mag = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;

	dqsa_div #(
		.N(SUM_W),
		.D(CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_mag),
		.divisor  (count_q),
		.quotient (quotient),
		.done     (div_done)
	);

	// average magnitude always fits 32 bits; restore the sign
	assign quo_lo = quotient[DATA_W-1:0];
	assign avg    = avg_neg_q ? (~quo_lo + DATA_W'(1)) : quo_lo;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_sel)
				RES_EMPTY: begin
					status_q <= ST_EMPTY;
					answer_q <= '0;
				end
				RES_FULL: begin
					status_q <= ST_FULL;
					answer_q <= '0;
				end
				RES_MISS: begin
					status_q <= ST_NOT_FOUND;
					answer_q <= '0;
				end
				RES_SIZE: begin
					status_q <= ST_OK;
					answer_q <= {{(DATA_W-CNT_W){1'b0}}, count_q};
				end
				RES_POS: begin
					status_q <= ST_OK;
					answer_q <= {{(DATA_W-IDX_W){1'b0}}, cmp_idx_q};
				end
				RES_AVG: begin
					status_q <= ST_OK;
					answer_q <= avg;
				end
				default: begin
					status_q <= ST_OK;
					answer_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_load;
		end
	end

	assign stat.func     = func_q;
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == CNT_W'(CAPACITY));
	assign stat.match    = (rdata_q == value_q);
	assign stat.last     = ((PW'(cmp_idx_q) + PW'(1)) == PW'(count_q));
	assign stat.div_done = div_done;

	assign done   = done_q;
	assign status = status_q;
	assign answer = answer_q;

endmodule

// ----- src/deque_with_search_and_average.sv -----
// Deque of signed 32-bit words with search and average, one word at a time.
// Push, size and rejected operations finish in the execute state; pops first
// do one memory read; search compares one entry per cycle from the front
// until a match or the last entry; average waits for the bit-serial divider.
// start is taken again once busy falls, in the same cycle as done.
// Reset clears head pointer, count and sum at once; entries are not cleared.
module deque_with_search_and_average #(
	parameter int CAPACITY = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [dqsa_pkg::FUNC_W-1:0]        func,
	input  logic signed [dqsa_pkg::DATA_W-1:0] value,
	output logic                               done,
	output logic [dqsa_pkg::STAT_W-1:0]        status,
	output logic signed [dqsa_pkg::DATA_W-1:0] answer
);
	import dqsa_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = DATA_W + CNT_W;

	dqsa_cmd_t  cmd;
	dqsa_stat_t stat;

	dqsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	dqsa_dp #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W),
		.SUM_W    (SUM_W)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.func   (func),
		.value  (value),
		.done   (done),
		.status (status),
		.answer (answer)
	);

endmodule

// ----- tb/tb_deque_with_search_and_average.sv -----
// ----------------------------------------------------------------------------
// tb_deque_with_search_and_average
// Drives push, pop, search, size and average words into the deque through the
// start/busy handshake and checks every done strobe against a local deque
// predictor. A short table of directed words comes first, then phases of
// random words that fill, drain, wrap and saturate the buffer.
// ----------------------------------------------------------------------------
module tb_deque_with_search_and_average;
	import dqsa_pkg::*;

	localparam int CAP = 256;
	localparam int RANDOM_WORDS = 1250;
	localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;
	localparam logic signed [DATA_W-1:0] MAX_WORD = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] MIN_WORD = 32'sh80000000;

	typedef enum int {PH_MIX, PH_FILL, PH_DRAIN, PH_SEARCH, PH_SATURATE} phase_t;

	typedef struct packed {
		logic [STAT_W-1:0]        st;
		logic signed [DATA_W-1:0] ans;
	} result_t;

	typedef struct packed {
		logic [FUNC_W-1:0]        fn;
		logic signed [DATA_W-1:0] val;
		logic                     typed;
		logic [STAT_W-1:0]        st;
		logic signed [DATA_W-1:0] ans;
	} row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [FUNC_W-1:0]        func;
	logic signed [DATA_W-1:0] value;
	logic                     done;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] answer;

	// typed expectation travelling with the word on the inputs
	logic                     typed_valid;
	logic [STAT_W-1:0]        typed_status;
	logic signed [DATA_W-1:0] typed_answer;

	// predictor state
	logic signed [DATA_W-1:0] held [CAP];
	int                       front_pos;
	int                       held_count;
	longint                   held_sum;

	result_t pending_results [$];
	bit      any_fail;
	int      issued;

	row_t plan [25] = '{
		'{FN_SIZE,      32'sd0,       1'b1, ST_OK,        32'sd0},
		'{FN_POP_FRONT, 32'sd0,       1'b1, ST_EMPTY,     32'sd0},
		'{FN_POP_BACK,  32'sd0,       1'b1, ST_EMPTY,     32'sd0},
		'{FN_AVERAGE,   32'sd0,       1'b1, ST_EMPTY,     32'sd0},
		'{FN_SEARCH,    32'sd0,       1'b1, ST_NOT_FOUND, 32'sd0},
		'{FN_UNUSED_6,  MAX_WORD,     1'b1, ST_OK,        32'sd0},
		'{FN_UNUSED_7,  MIN_WORD,     1'b1, ST_OK,        32'sd0},
		'{FN_PUSH_BACK, MAX_WORD,     1'b1, ST_OK,        32'sd0},
		'{FN_PUSH_BACK, MIN_WORD,     1'b1, ST_OK,        32'sd0},
		'{FN_PUSH_BACK, -32'sd1,      1'b1, ST_OK,        32'sd0},
		'{FN_PUSH_BACK, 32'sd0,       1'b1, ST_OK,        32'sd0},
		'{FN_SIZE,      32'sd0,       1'b1, ST_OK,        32'sd4},
		'{FN_SEARCH,    MIN_WORD,     1'b1, ST_OK,        32'sd1},
		'{FN_SEARCH,    32'sd0,       1'b1, ST_OK,        32'sd3},
		'{FN_SEARCH,    32'sd5,       1'b1, ST_NOT_FOUND, 32'sd0},
		// sum is -2 over four words: truncates toward zero
		'{FN_AVERAGE,   32'sd0,       1'b1, ST_OK,        32'sd0},
		'{FN_PUSH_BACK, 32'sd7,       1'b0, ST_OK,        32'sd0},
		'{FN_PUSH_BACK, 32'sd7,       1'b0, ST_OK,        32'sd0},
		// duplicate: first match from the front wins
		'{FN_SEARCH,    32'sd7,       1'b1, ST_OK,        32'sd4},
		'{FN_POP_FRONT, 32'sd0,       1'b1, ST_OK,        32'sd0},
		'{FN_SEARCH,    32'sd7,       1'b0, ST_OK,        32'sd0},
		'{FN_AVERAGE,   32'sd0,       1'b0, ST_OK,        32'sd0},
		'{FN_POP_BACK,  32'sd0,       1'b1, ST_OK,        32'sd0},
		'{FN_POP_BACK,  32'sd0,       1'b0, ST_OK,        32'sd0},
		'{FN_AVERAGE,   32'sd0,       1'b0, ST_OK,        32'sd0}
	};

	deque_with_search_and_average u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.func   (func),
		.value  (value),
		.done   (done),
		.status (status),
		.answer (answer)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	// apply one operation to the local deque and return its result
	function automatic result_t deque_op(input logic [FUNC_W-1:0] fn,
			input logic signed [DATA_W-1:0] v);
		result_t r;
		bit      hit;
		r.st = ST_OK;
		r.ans = '0;
		hit = 1'b0;
		case (fn)
			FN_PUSH_BACK: begin
				if (held_count == CAP) begin
					r.st = ST_FULL;
				end else begin
					held[(front_pos + held_count) % CAP] = v;
					held_count++;
					held_sum += v;
				end
			end
			FN_POP_FRONT: begin
				if (held_count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					held_sum -= held[front_pos];
					front_pos = (front_pos + 1) % CAP;
					held_count--;
				end
			end
			FN_POP_BACK: begin
				if (held_count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					held_sum -= held[(front_pos + held_count - 1) % CAP];
					held_count--;
				end
			end
			FN_SEARCH: begin
				r.st = ST_NOT_FOUND;
				for (int i = 0; i < held_count; i++) begin
					if (!hit && held[(front_pos + i) % CAP] == v) begin
						hit = 1'b1;
						r.st = ST_OK;
						r.ans = i;
					end
				end
			end
			FN_SIZE: r.ans = held_count;
			FN_AVERAGE: begin
				if (held_count == 0)
					r.st = ST_EMPTY;
				else
					r.ans = DATA_W'(held_sum / held_count);
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (done) begin
				got.st = status;
				got.ans = answer;
				if (pending_results.size() == 0) begin
					$display("%0t: result with no word pending: status %0d answer %0d",
						$time, got.st, got.ans);
					any_fail = 1'b1;
				end else begin
					want = pending_results.pop_front();
					if (got.st !== want.st) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.st, got.st);
						any_fail = 1'b1;
					end
					if (got.ans !== want.ans) begin
						$display("%0t: answer mismatch: expected %0d, actual %0d",
							$time, want.ans, got.ans);
						any_fail = 1'b1;
					end
				end
			end
			if (start && !busy) begin
				want = deque_op(func, value);
				if (typed_valid) begin
					want.st = typed_status;
					want.ans = typed_answer;
				end
				pending_results.push_back(want);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return $urandom_range(0, 1) ? MAX_WORD : MIN_WORD;
		else if (r < 35)
			return $signed($urandom_range(0, 15)) - 8;
		else
			return $urandom;
	endfunction

	// search value that hits a held word most of the time
	function automatic logic signed [DATA_W-1:0] search_word();
		if (held_count > 0 && $urandom_range(0, 99) < 60)
			return held[(front_pos + $urandom_range(0, held_count - 1)) % CAP];
		return rand_word();
	endfunction

	function automatic logic [FUNC_W-1:0] pick_op(input phase_t ph);
		int r;
		r = $urandom_range(0, 99);
		case (ph)
			PH_FILL: begin
				if (r < 70) return FN_PUSH_BACK;
				if (r < 78) return FN_POP_FRONT;
				if (r < 84) return FN_POP_BACK;
				if (r < 92) return FN_SEARCH;
				if (r < 96) return FN_SIZE;
				return FN_AVERAGE;
			end
			PH_DRAIN: begin
				if (r < 15) return FN_PUSH_BACK;
				if (r < 50) return FN_POP_FRONT;
				if (r < 80) return FN_POP_BACK;
				if (r < 88) return FN_SEARCH;
				if (r < 93) return FN_SIZE;
				return FN_AVERAGE;
			end
			PH_SEARCH: begin
				if (r < 25) return FN_PUSH_BACK;
				if (r < 30) return FN_POP_FRONT;
				if (r < 35) return FN_POP_BACK;
				if (r < 85) return FN_SEARCH;
				if (r < 90) return FN_SIZE;
				return FN_AVERAGE;
			end
			default: begin
				if (r < 35) return FN_PUSH_BACK;
				if (r < 50) return FN_POP_FRONT;
				if (r < 65) return FN_POP_BACK;
				if (r < 80) return FN_SEARCH;
				if (r < 88) return FN_SIZE;
				if (r < 97) return FN_AVERAGE;
				return $urandom_range(0, 1) ? FN_UNUSED_6 : FN_UNUSED_7;
			end
		endcase
	endfunction

	// hold the word until accepted, then drop start for the gap if one is given; ends at a falling edge
	task automatic send_word(input logic [FUNC_W-1:0] fn, input logic signed [DATA_W-1:0] v,
			input logic chk, input logic [STAT_W-1:0] st,
			input logic signed [DATA_W-1:0] ans, input int gap);
		start <= 1'b1;
		func <= fn;
		value <= v;
		typed_valid <= chk;
		typed_status <= st;
		typed_answer <= ans;
		do
			@(posedge clk);
		while (busy);
		if (fn != FN_UNUSED_6 && fn != FN_UNUSED_7)
			issued++;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_random(input phase_t ph, input bit no_gaps);
		logic [FUNC_W-1:0]        fn;
		logic signed [DATA_W-1:0] v;
		fn = pick_op(ph);
		v = (fn == FN_SEARCH) ? search_word() : rand_word();
		send_word(fn, v, 1'b0, ST_OK, '0, no_gaps ? 0 : pick_gap());
	endtask

	// drop start and wait for every result
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending_results.size() != 0);
	endtask

	initial begin
		phase_t                   ph;
		bit                       no_gaps;
		int                       phase_no;
		int                       len;
		int                       fill_mode;
		logic signed [DATA_W-1:0] v;

		arst_n = 1'b0;
		start = 1'b0;
		func = FN_SIZE;
		value = '0;
		typed_valid = 1'b0;
		typed_status = ST_OK;
		typed_answer = '0;
		front_pos = 0;
		held_count = 0;
		held_sum = 0;
		any_fail = 1'b0;
		issued = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_word(plan[i].fn, plan[i].val, plan[i].typed, plan[i].st, plan[i].ans,
				pick_gap());

		issued = 0;
		phase_no = 0;
		while (issued < RANDOM_WORDS) begin
			// on the first phase, and at random otherwise, let every result come home first
			if (phase_no == 0 || $urandom_range(0, 4) == 0)
				wait_drained();
			no_gaps = ($urandom_range(0, 3) == 0);
			if (phase_no == 0) begin
				ph = PH_SATURATE;
			end else begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7: ph = PH_MIX;
					8, 9, 10, 11:           ph = PH_FILL;
					12, 13, 14, 15:         ph = PH_DRAIN;
					16, 17, 18:             ph = PH_SEARCH;
					default:                ph = PH_SATURATE;
				endcase
			end
			if (ph == PH_SATURATE) begin
				// fill to capacity with extreme or random words, then hit the full case and query
				fill_mode = $urandom_range(0, 2);
				while (held_count < CAP) begin
					case (fill_mode)
						0:       v = MAX_WORD;
						1:       v = MIN_WORD;
						default: v = rand_word();
					endcase
					send_word(FN_PUSH_BACK, v, 1'b0, ST_OK, '0, no_gaps ? 0 : pick_gap());
				end
				send_word(FN_PUSH_BACK, rand_word(), 1'b1, ST_FULL, '0, pick_gap());
				send_word(FN_PUSH_BACK, MAX_WORD, 1'b1, ST_FULL, '0, pick_gap());
				send_word(FN_SIZE, '0, 1'b1, ST_OK, CAP, pick_gap());
				send_word(FN_AVERAGE, '0, 1'b0, ST_OK, '0, pick_gap());
				send_word(FN_SEARCH, search_word(), 1'b0, ST_OK, '0, pick_gap());
				send_word(FN_SEARCH, rand_word(), 1'b0, ST_OK, '0, pick_gap());
			end else begin
				len = $urandom_range(20, (ph == PH_FILL || ph == PH_DRAIN) ? 300 : 60);
				if (len > RANDOM_WORDS - issued)
					len = RANDOM_WORDS - issued;
				repeat (len)
					send_random(ph, no_gaps);
			end
			phase_no++;
		end

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (!any_fail)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
src/dqsa_pkg.sv
src/dqsa_div.sv
src/dqsa_ctrl.sv
src/dqsa_dp.sv
src/deque_with_search_and_average.sv
tb/tb_deque_with_search_and_average.sv
